// ===== rtl/trs_pkg.sv =====
// trs_pkg: shared types and codes for the tick resource allocation scheduler
// used by trs_cell, trs_ctrl, the top level and the checker
package trs_pkg;

    typedef enum logic [2:0] {
        ST_FINISHED  = 3'd0,
        ST_UNARRIVED = 3'd1,
        ST_INVALID   = 3'd2,
        ST_ARRIVED   = 3'd3,
        ST_IARRIVED  = 3'd4,
        ST_STARTED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        EV_FINISHED = 3'd0,
        EV_ARRIVED  = 3'd1,
        EV_STARTED  = 3'd2,
        EV_TICK     = 3'd3,
        EV_ENDED    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_FIN,
        PH_ARR,
        PH_START,
        PH_DONE
    } t_phase;

    localparam int unsigned REG_TOTAL0 = 0;
    localparam int unsigned REG_TOTAL3 = 3;
    localparam int unsigned REG_TYPES  = 4;
    localparam int unsigned REG_JOBS   = 5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // control sent down the row of cells
    typedef struct packed {
        logic   load;
        logic   rotate;
    } t_cell_ctl;

endpackage

// ===== rtl/tick_resource_allocation_scheduler.sv =====
// tick_resource_allocation_scheduler: the job ring of trs_cell, the trs_ctrl sequencer,
// free pool and time. depends on trs_pkg, trs_cell, trs_ctrl
//
// usage: pulse start with the fields while busy is low. a load (i_func=0) writes one
// table entry, resets time and pool, and yields no beat; the ring makes one full lap
// to bring the entry past the head, and busy stays high through the lap.
// a tick (i_func=1) yields its beats on o_valid, one per cycle at most, last beat
// flagged by o_last. the job table is a ring of MAX_JOBS cells; the whole ring
// rotates by one per cycle during a pass or a load so the head cell is the entry under work.
// a tick runs a scan step, three passes over the ring (finish, arrive, start) and a
// closing step, with busy high throughout.
// the last beat shows in the first cycle after busy drops, which is also the first
// cycle in which the next item can be taken.
// a tick when nothing runs or waits skips the passes and yields one run-ended beat.
// the ring length, not job_count, sets the pass length so the ring comes home.
// configuration writes go through i_cfg_we/i_cfg_idx/i_cfg_data any time idle.
// reset clears all entries to finished, time and pool to zero, types_in_use to 4.
// the receiver cannot stall: each beat is shown for exactly one cycle.
module tick_resource_allocation_scheduler #(
    parameter int unsigned MAX_JOBS  = 16,
    parameter int unsigned NUM_TYPES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_func,
    input  logic [3:0]                      i_job_index,
    input  logic [7:0]                      i_need_type0,
    input  logic [7:0]                      i_need_type1,
    input  logic [7:0]                      i_need_type2,
    input  logic [7:0]                      i_need_type3,
    input  logic [15:0]                     i_arrival_time,
    input  logic [15:0]                     i_service_time,
    output logic                            o_valid,
    output logic [2:0]                      o_event_kind,
    output logic [3:0]                      o_event_job,
    output logic [31:0]                     o_event_time,
    output logic                            o_halted,
    output logic                            o_last
);
    localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    logic [7:0] r_total [4];
    logic [2:0] r_types;
    logic [4:0] r_jobs;
    logic [7:0] r_free [4];
    logic [31:0] r_time;
    logic r_run, r_wait, r_halt;
    logic r_halt_done;
    logic r_lpend;
    logic [IDX_W-1:0] r_lidx;
    logic [31:0] r_lneeds;
    logic [15:0] r_larr, r_lsvc;
    logic r_lbad;

    trs_pkg::t_phase phase;
    logic [IDX_W:0] step;
    logic ctrl_busy;

    trs_pkg::t_status st [MAX_JOBS];
    logic [31:0] nd [MAX_JOBS];
    logic [15:0] ar [MAX_JOBS];
    logic [15:0] rm [MAX_JOBS];
    trs_pkg::t_cell_ctl ctl;

    logic [2:0] nt;
    logic [6:0] nj;
    logic head_in;
    logic [IDX_W:0] depth;
    logic accept, is_tick, is_load;
    logic [IDX_W:0] load_rot;

    assign accept  = start && !busy;
    assign is_tick = accept && i_func;
    assign is_load = accept && !i_func && (32'(i_job_index) < MAX_JOBS);
    assign busy    = ctrl_busy || r_lpend;
    assign depth   = (IDX_W+1)'(MAX_JOBS);
    assign nt      = (r_types > 3'(NUM_TYPES)) ? 3'(NUM_TYPES) : r_types;
    assign nj      = (32'(r_jobs) > MAX_JOBS) ? 7'(MAX_JOBS) : 7'(r_jobs);
    assign head_in = (7'(step) < nj);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 4; t++) r_total[t] <= '0;
            r_types <= 3'd4;
            r_jobs  <= '0;
        end else if (i_cfg_we) begin
            if (32'(i_cfg_idx) <= trs_pkg::REG_TOTAL3)
                r_total[i_cfg_idx[1:0]] <= i_cfg_data;
            else if (32'(i_cfg_idx) == trs_pkg::REG_TYPES)
                r_types <= i_cfg_data[2:0];
            else if (32'(i_cfg_idx) == trs_pkg::REG_JOBS)
                r_jobs <= i_cfg_data[4:0];
        end
    end

    // a load rotates the ring one full lap; when the target entry is at the head
    // the new entry goes into the tail in its place
    logic [IDX_W:0] r_lcnt;
    always_comb begin
        load_rot = '0;
        load_rot[IDX_W-1:0] = r_lidx;
    end

    // cell ring wiring
    trs_pkg::t_status hs;
    logic [31:0] hn;
    logic [15:0] ha, hr;
    assign hs = st[0];
    assign hn = nd[0];
    assign ha = ar[0];
    assign hr = rm[0];

    // new head value that leaves the head cell into the tail
    trs_pkg::t_status new_st;
    logic fin_ev, arr_ev, stt_ev, fits;
    always_comb begin
        fits = 1'b1;
        for (int t = 0; t < 4; t++)
            if (3'(t) < nt && hn[8*t +: 8] > r_free[t]) fits = 1'b0;
    end
    always_comb begin
        new_st = hs;
        fin_ev = 1'b0;
        arr_ev = 1'b0;
        stt_ev = 1'b0;
        if (head_in) begin
            case (phase)
                trs_pkg::PH_FIN:
                    if (hs == trs_pkg::ST_STARTED && hr == 16'd0) begin
                        new_st = trs_pkg::ST_FINISHED; fin_ev = 1'b1;
                    end
                trs_pkg::PH_ARR:
                    if ((hs == trs_pkg::ST_UNARRIVED || hs == trs_pkg::ST_INVALID) &&
                        r_time >= 32'(ha)) begin
                        new_st = (hs == trs_pkg::ST_INVALID) ? trs_pkg::ST_IARRIVED
                                                             : trs_pkg::ST_ARRIVED;
                        arr_ev = 1'b1;
                    end
                trs_pkg::PH_START:
                    if (hs == trs_pkg::ST_ARRIVED && fits) begin
                        new_st = trs_pkg::ST_STARTED; stt_ev = 1'b1;
                    end
                default: ;
            endcase
        end
    end

    logic in_pass;
    assign in_pass = (phase == trs_pkg::PH_FIN || phase == trs_pkg::PH_ARR ||
                      phase == trs_pkg::PH_START);
    assign ctl.rotate = in_pass || r_lpend;
    assign ctl.load   = r_lpend && (r_lcnt == load_rot);

    // countdown rides the start pass: an entry's state is final once the head passes it
    logic dec_head;
    assign dec_head = (phase == trs_pkg::PH_START) && head_in &&
                      (new_st == trs_pkg::ST_STARTED) && (hr != 16'd0);

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        trs_pkg::t_status si;
        logic [31:0] ni;
        logic [15:0] ai, ri;
        if (g == MAX_JOBS - 1) begin : g_tail
            always_comb begin
                if (ctl.load) begin
                    si = r_lbad ? trs_pkg::ST_INVALID : trs_pkg::ST_UNARRIVED;
                    ni = r_lneeds; ai = r_larr; ri = r_lsvc;
                end else begin
                    si = in_pass ? new_st : hs;
                    ni = hn; ai = ha;
                    ri = dec_head ? hr - 16'd1 : hr;
                end
            end
        end else begin : g_mid
            always_comb begin
                si = st[g+1]; ni = nd[g+1]; ai = ar[g+1]; ri = rm[g+1];
            end
        end
        trs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_head    (g == MAX_JOBS - 1),
            .i_status  (si),
            .i_needs   (ni),
            .i_arrival (ai),
            .i_remain  (ri),
            .o_status  (st[g]),
            .o_needs   (nd[g]),
            .o_arrival (ar[g]),
            .o_remain  (rm[g])
        );
    end

    // load lap: one rotation per cycle until the ring is home again
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpend <= 1'b0;
            r_lcnt  <= '0;
        end else if (is_load) begin
            r_lpend <= 1'b1;
            r_lcnt  <= '0;
        end else if (r_lpend) begin
            r_lcnt <= r_lcnt + 1'b1;
            if (r_lcnt == depth - 1'b1) r_lpend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_load) begin
            r_lidx   <= IDX_W'(i_job_index);
            r_lneeds <= {i_need_type3, i_need_type2, i_need_type1, i_need_type0};
            r_larr   <= i_arrival_time;
            r_lsvc   <= i_service_time;
            r_lbad   <= (i_need_type0 > r_total[0] && nt > 3'd0) ||
                        (i_need_type1 > r_total[1] && nt > 3'd1) ||
                        (i_need_type2 > r_total[2] && nt > 3'd2) ||
                        (i_need_type3 > r_total[3] && nt > 3'd3);
        end
    end

    trs_ctrl #(.IDX_W(IDX_W)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (is_tick),
        .i_depth (depth),
        .i_over  (!r_run && !r_wait),
        .o_phase (phase),
        .o_step  (step),
        .o_busy  (ctrl_busy)
    );

    // run/wait/halt flags from the cells below job_count (one per cell), latched in PH_IDLE for PH_SCAN
    logic any_run, any_wait, any_halt;
    always_comb begin
        any_run = 1'b0; any_wait = 1'b0; any_halt = 1'b0;
        for (int g = 0; g < MAX_JOBS; g++) begin
            if (7'(g) < nj) begin
                if (st[g] == trs_pkg::ST_STARTED) any_run = 1'b1;
                if (st[g] != trs_pkg::ST_INVALID && st[g] != trs_pkg::ST_FINISHED &&
                    st[g] != trs_pkg::ST_IARRIVED) any_wait = 1'b1;
                if (st[g] == trs_pkg::ST_INVALID || st[g] == trs_pkg::ST_IARRIVED)
                    any_halt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_wait <= 1'b0; r_halt <= 1'b0; r_halt_done <= 1'b0;
        end else if (phase == trs_pkg::PH_IDLE) begin
            r_run <= any_run; r_wait <= any_wait; r_halt <= any_halt;
        end else if (phase == trs_pkg::PH_SCAN) begin
            r_halt_done <= !r_run && !r_wait;
        end
    end

    // free pool and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 4; t++) r_free[t] <= '0;
            r_time <= '0;
        end else if (is_load) begin
            for (int t = 0; t < 4; t++) r_free[t] <= r_total[t];
            r_time <= '0;
        end else begin
            for (int t = 0; t < 4; t++) begin
                if (3'(t) < nt) begin
                    if (fin_ev)
                        r_free[t] <= (9'(r_free[t]) + 9'(hn[8*t +: 8]) > 9'd255) ? 8'd255
                                     : r_free[t] + hn[8*t +: 8];
                    else if (stt_ev)
                        r_free[t] <= r_free[t] - hn[8*t +: 8];
                end
            end
            if (phase == trs_pkg::PH_DONE && !r_halt_done) r_time <= r_time + 32'd1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= fin_ev || arr_ev || stt_ev || (phase == trs_pkg::PH_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        o_event_time <= r_time;
        o_event_job  <= 4'(step);
        o_halted     <= 1'b0;
        o_last       <= 1'b0;
        if (fin_ev) o_event_kind <= trs_pkg::EV_FINISHED;
        else if (arr_ev) o_event_kind <= trs_pkg::EV_ARRIVED;
        else if (stt_ev) o_event_kind <= trs_pkg::EV_STARTED;
        else begin
            o_event_job <= '0;
            o_last      <= 1'b1;
            if (r_halt_done) begin
                o_event_kind <= trs_pkg::EV_ENDED;
                o_halted     <= r_halt;
            end else begin
                o_event_kind <= trs_pkg::EV_TICK;
            end
        end
    end
endmodule

// ===== rtl/trs_cell.sv =====
// trs_cell: one table entry of the job ring; shifts its entry to the neighbor on rotate
// depends on trs_pkg
module trs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trs_pkg::t_cell_ctl  i_ctl,
    input  logic                i_head,
    input  trs_pkg::t_status    i_status,
    input  logic [31:0]         i_needs,
    input  logic [15:0]         i_arrival,
    input  logic [15:0]         i_remain,
    output trs_pkg::t_status    o_status,
    output logic [31:0]         o_needs,
    output logic [15:0]         o_arrival,
    output logic [15:0]         o_remain
);
    trs_pkg::t_status r_status;
    logic [31:0] r_needs;
    logic [15:0] r_arrival, r_remain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= trs_pkg::ST_FINISHED;
        end else if (i_ctl.rotate || (i_ctl.load && i_head)) begin
            r_status <= i_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate || (i_ctl.load && i_head)) begin
            r_needs   <= i_needs;
            r_arrival <= i_arrival;
            r_remain  <= i_remain;
        end
    end

    assign o_status  = r_status;
    assign o_needs   = r_needs;
    assign o_arrival = r_arrival;
    assign o_remain  = r_remain;
endmodule

// ===== rtl/trs_ctrl.sv =====
// trs_ctrl: phase sequencer for one tick, walks the ring one entry per cycle
// depends on trs_pkg
module trs_ctrl #(
    parameter int unsigned IDX_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic [IDX_W:0]      i_depth,
    input  logic                i_over,
    output trs_pkg::t_phase     o_phase,
    output logic [IDX_W:0]      o_step,
    output logic                o_busy
);
    trs_pkg::t_phase r_phase, n_phase;
    logic [IDX_W:0] r_step, n_step;
    logic last_step;

    assign last_step = (r_step == i_depth - 1'b1);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            trs_pkg::PH_IDLE:  if (i_tick) n_phase = trs_pkg::PH_SCAN;
            trs_pkg::PH_SCAN:  n_phase = i_over ? trs_pkg::PH_DONE : trs_pkg::PH_FIN;
            trs_pkg::PH_FIN:   if (last_step) n_phase = trs_pkg::PH_ARR;
            trs_pkg::PH_ARR:   if (last_step) n_phase = trs_pkg::PH_START;
            trs_pkg::PH_START: if (last_step) n_phase = trs_pkg::PH_DONE;
            trs_pkg::PH_DONE:  n_phase = trs_pkg::PH_IDLE;
            default:           n_phase = trs_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        n_step = '0;
        if ((r_phase == trs_pkg::PH_FIN || r_phase == trs_pkg::PH_ARR ||
             r_phase == trs_pkg::PH_START) && !last_step) begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= trs_pkg::PH_IDLE;
            r_step  <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

    assign o_phase = r_phase;
    assign o_step  = r_step;
    assign o_busy  = (r_phase != trs_pkg::PH_IDLE);
endmodule

// ===== rtl/trs_checker.sv =====
// trs_checker: port-level checks for the scheduler, bound to the top level
// depends on trs_pkg and the tick_resource_allocation_scheduler ports
module trs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_event_kind,
    input logic        o_last,
    input logic        o_halted
);
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_event_kind == trs_pkg::EV_TICK ||
                               o_event_kind == trs_pkg::EV_ENDED))
        else $error("last beat not a tick end");
    a_halt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> o_event_kind == trs_pkg::EV_ENDED)
        else $error("halted on wrong beat");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("beat after last");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("inner beat while idle");
    a_accept_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && o_valid |-> o_last)
        else $error("item taken before the last beat");
endmodule

bind tick_resource_allocation_scheduler trs_checker u_trs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid),
    .o_event_kind(o_event_kind), .o_last(o_last), .o_halted(o_halted)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for tick_resource_allocation_scheduler
// depends on trs_pkg and the scheduler rtl; a directed table, then random job sets per setting
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NJOB    = 16;
    localparam int SETTLE  = 60;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        trs_pkg::t_event kind;
        logic [3:0]  job;
        logic [31:0] stamp;
        logic        halt;
        logic        lastb;
    } t_sched_event;

    typedef struct {
        bit          func;
        logic [3:0]  idx;
        logic [7:0]  n0, n1, n2, n3;
        logic [15:0] arr, svc;
        bit          chk_end;
        bit          halt;
    } t_stim_row;

    logic        i_clk, i_rst_n, start, busy;
    logic        i_cfg_we;
    logic [trs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [trs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic        i_func;
    logic [3:0]  i_job_index;
    logic [7:0]  i_need_type0, i_need_type1, i_need_type2, i_need_type3;
    logic [15:0] i_arrival_time, i_service_time;
    logic        o_valid, o_halted, o_last;
    logic [2:0]  o_event_kind;
    logic [3:0]  o_event_job;
    logic [31:0] o_event_time;

    tick_resource_allocation_scheduler dut (.*);

    // scheduler mirror
    logic [7:0]  total_units [4];
    logic [2:0]  types_reg;
    logic [4:0]  jobs_reg;
    trs_pkg::t_status status_m [NJOB];
    logic [7:0]  need_m [NJOB][4];
    logic [15:0] arrive_m [NJOB];
    logic [15:0] remain_m [NJOB];
    logic [7:0]  pool_m [4];
    logic [31:0] clock_m;

    t_sched_event pending_events [$];
    int  errors;
    int  burst_left;
    bit  gaps_on;
    int  idle_cycles;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int type_limit();
        return (types_reg > 4) ? 4 : int'(types_reg);
    endfunction

    function automatic int job_limit();
        return (jobs_reg > NJOB) ? NJOB : int'(jobs_reg);
    endfunction

    function automatic void push_event(trs_pkg::t_event k, int j, bit h);
        t_sched_event e;
        e.kind = k;
        e.job = 4'(j);
        e.stamp = clock_m;
        e.halt = h;
        e.lastb = 0;
        pending_events.push_back(e);
    endfunction

    function automatic void cfg_mirror(int idx, logic [7:0] val);
        if (idx <= int'(trs_pkg::REG_TOTAL3)) total_units[idx] = val;
        else if (idx == int'(trs_pkg::REG_TYPES)) types_reg = val[2:0];
        else if (idx == int'(trs_pkg::REG_JOBS)) jobs_reg = val[4:0];
    endfunction

    function automatic void schedule_item(t_stim_row r);
        int nt, nj;
        bit bad, running, waiting, halt, ok;
        int v;
        nt = type_limit();
        nj = job_limit();
        if (!r.func) begin
            need_m[r.idx][0] = r.n0;
            need_m[r.idx][1] = r.n1;
            need_m[r.idx][2] = r.n2;
            need_m[r.idx][3] = r.n3;
            bad = 0;
            for (int t = 0; t < nt; t++)
                if (need_m[r.idx][t] > total_units[t]) bad = 1;
            arrive_m[r.idx] = r.arr;
            remain_m[r.idx] = r.svc;
            status_m[r.idx] = bad ? trs_pkg::ST_INVALID : trs_pkg::ST_UNARRIVED;
            clock_m = 0;
            for (int t = 0; t < 4; t++) pool_m[t] = total_units[t];
            return;
        end
        running = 0; waiting = 0; halt = 0;
        for (int i = 0; i < nj; i++) begin
            if (status_m[i] == trs_pkg::ST_STARTED) running = 1;
            if (!(status_m[i] inside {trs_pkg::ST_INVALID, trs_pkg::ST_FINISHED,
                                      trs_pkg::ST_IARRIVED})) waiting = 1;
            if (status_m[i] inside {trs_pkg::ST_INVALID, trs_pkg::ST_IARRIVED}) halt = 1;
        end
        if (!running && !waiting) begin
            push_event(trs_pkg::EV_ENDED, 0, halt);
            pending_events[pending_events.size()-1].lastb = 1;
            return;
        end
        for (int i = 0; i < nj; i++)
            if (status_m[i] == trs_pkg::ST_STARTED && remain_m[i] == 0) begin
                status_m[i] = trs_pkg::ST_FINISHED;
                push_event(trs_pkg::EV_FINISHED, i, 0);
                for (int t = 0; t < nt; t++) begin
                    v = int'(pool_m[t]) + int'(need_m[i][t]);
                    pool_m[t] = (v > 255) ? 8'd255 : 8'(v);
                end
            end
        for (int i = 0; i < nj; i++)
            if (status_m[i] inside {trs_pkg::ST_UNARRIVED, trs_pkg::ST_INVALID} &&
                clock_m >= 32'(arrive_m[i])) begin
                status_m[i] = (status_m[i] == trs_pkg::ST_INVALID) ? trs_pkg::ST_IARRIVED
                                                                   : trs_pkg::ST_ARRIVED;
                push_event(trs_pkg::EV_ARRIVED, i, 0);
            end
        for (int i = 0; i < nj; i++)
            if (status_m[i] == trs_pkg::ST_ARRIVED) begin
                ok = 1;
                for (int t = 0; t < nt; t++)
                    if (need_m[i][t] > pool_m[t]) ok = 0;
                if (ok) begin
                    status_m[i] = trs_pkg::ST_STARTED;
                    push_event(trs_pkg::EV_STARTED, i, 0);
                    for (int t = 0; t < nt; t++) pool_m[t] = pool_m[t] - need_m[i][t];
                end
            end
        for (int i = 0; i < nj; i++)
            if (status_m[i] == trs_pkg::ST_STARTED && remain_m[i] != 0) remain_m[i]--;
        push_event(trs_pkg::EV_TICK, 0, 0);
        pending_events[pending_events.size()-1].lastb = 1;
        clock_m++;
    endfunction

    // result checker: a beat lives for exactly one cycle
    always @(posedge i_clk) begin
        t_sched_event e;
        if (i_rst_n && o_valid) begin
            if (pending_events.size() == 0) begin
                report("unexpected beat, kind", o_event_kind, -1);
            end else begin
                e = pending_events.pop_front();
                if (o_event_kind !== e.kind) report("event_kind", o_event_kind, e.kind);
                if (o_event_job !== e.job) report("event_job", o_event_job, e.job);
                if (o_event_time !== e.stamp) report("event_time", o_event_time, e.stamp);
                if (o_halted !== e.halt) report("halted", o_halted, e.halt);
                if (o_last !== e.lastb) report("last", o_last, e.lastb);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tick_resource_allocation_scheduler regression: fail");
            $finish;
        end
    end

    task automatic send_item(input t_stim_row r);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 8);
            start = 0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        start = 1;
        i_func = r.func;
        i_job_index = r.idx;
        i_need_type0 = r.n0;
        i_need_type1 = r.n1;
        i_need_type2 = r.n2;
        i_need_type3 = r.n3;
        i_arrival_time = r.arr;
        i_service_time = r.svc;
        do @(posedge i_clk); while (busy);
        schedule_item(r);
        @(negedge i_clk);
    endtask

    // the block is idle once no result is due and the last load has settled
    task automatic drain();
        start = 0;
        wait (pending_events.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [7:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx[trs_pkg::CFG_IDX_W-1:0];
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
        cfg_mirror(idx, val);
    endtask

    function automatic t_stim_row mk(bit f, int idx, int a, int b, int c, int d,
                                     int arr, int svc, bit chk, bit h);
        t_stim_row r;
        r.func = f; r.idx = 4'(idx);
        r.n0 = 8'(a); r.n1 = 8'(b); r.n2 = 8'(c); r.n3 = 8'(d);
        r.arr = 16'(arr); r.svc = 16'(svc);
        r.chk_end = chk; r.halt = h;
        return r;
    endfunction

    function automatic logic [7:0] pick_total();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_need(int t);
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, int'(total_units[t])));
    endfunction

    t_stim_row dir_rows [18];

    initial begin
        int qn, nj, nitems;
        t_stim_row r;
        errors = 0;
        burst_left = 0;
        gaps_on = 1;
        start = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        i_func = 0; i_job_index = '0;
        i_need_type0 = '0; i_need_type1 = '0; i_need_type2 = '0; i_need_type3 = '0;
        i_arrival_time = '0; i_service_time = '0;
        for (int t = 0; t < 4; t++) begin
            total_units[t] = 0;
            pool_m[t] = 0;
        end
        types_reg = 3'd4;
        jobs_reg = 5'd0;
        clock_m = 0;
        for (int i = 0; i < NJOB; i++) status_m[i] = trs_pkg::ST_FINISHED;

        // row 0 runs on reset settings; row 1 on the narrow pool below
        dir_rows = '{
            mk(1, 0, 0, 0, 0, 0, 0, 0, 1, 0),
            mk(0, 0, 5, 5, 5, 5, 0, 0, 0, 0),             // zero service time
            mk(0, 1, 11, 0, 0, 0, 1, 3, 0, 0),            // over the total: invalid
            mk(0, 2, 10, 20, 30, 255, 0, 2, 0, 0),        // needs equal to totals
            mk(0, 3, 0, 0, 0, 0, 65535, 65535, 0, 0),
            mk(0, 15, 255, 255, 255, 255, 0, 1, 0, 0),    // beyond job_count
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(0, 3, 0, 0, 0, 0, 0, 0, 0, 0),             // reload mid run: pool refills
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(1, 15, 255, 255, 255, 255, 65535, 65535, 0, 0)
        };

        i_rst_n = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (k == 1) begin
                drain();
                write_reg(trs_pkg::REG_TOTAL0, 8'd10);
                write_reg(trs_pkg::REG_TOTAL0 + 1, 8'd20);
                write_reg(trs_pkg::REG_TOTAL0 + 2, 8'd30);
                write_reg(trs_pkg::REG_TOTAL3, 8'd255);
                write_reg(trs_pkg::REG_TYPES, 8'd4);
                write_reg(trs_pkg::REG_JOBS, 8'd4);
            end
            qn = pending_events.size();
            send_item(dir_rows[k]);
            if (dir_rows[k].chk_end) begin
                if (pending_events.size() != qn + 1 ||
                    pending_events[qn].kind != trs_pkg::EV_ENDED)
                    report("directed run-ended beat count", pending_events.size() - qn, 1);
                else if (pending_events[qn].halt != dir_rows[k].halt)
                    report("directed halted", pending_events[qn].halt, dir_rows[k].halt);
            end
        end

        // random job sets, one per setting
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            gaps_on = (ph % 3 != 2);
            for (int t = 0; t < 4; t++) write_reg(trs_pkg::REG_TOTAL0 + t, pick_total());
            case (ph)
                0: write_reg(trs_pkg::REG_TYPES, 8'd0);
                1: write_reg(trs_pkg::REG_TYPES, 8'd7);
                2: write_reg(trs_pkg::REG_TYPES, 8'd1);
                default: write_reg(trs_pkg::REG_TYPES, 8'($urandom_range(0, 7)));
            endcase
            case (ph)
                3: write_reg(trs_pkg::REG_JOBS, 8'd0);
                4: write_reg(trs_pkg::REG_JOBS, 8'd16);
                5: write_reg(trs_pkg::REG_JOBS, 8'd31);
                default: write_reg(trs_pkg::REG_JOBS, 8'($urandom_range(1, 6)));
            endcase
            if ($urandom_range(0, 3) == 0) write_reg($urandom_range(6, 7), 8'($urandom));
            nj = job_limit();
            nitems = 0;
            for (int j = 0; j < nj; j++) begin
                r = mk(0, j, pick_need(0), pick_need(1), pick_need(2), pick_need(3),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 6),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 5), 0, 0);
                send_item(r);
                nitems++;
            end
            while (nitems < 24) begin
                if ($urandom_range(0, 9) == 0)
                    r = mk(0, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
                else
                    r = mk(1, $urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
                send_item(r);
                nitems++;
            end
        end

        drain();
        if (errors == 0)
            $display("tick_resource_allocation_scheduler regression: pass");
        else
            $display("tick_resource_allocation_scheduler regression: fail");
        $finish;
    end
endmodule
